/* rtl/core/crtg_pkg.sv */
package crtg_pkg;

    localparam int NMOD = 5;

    typedef logic [30:0] t_resid;
    typedef logic [2:0]  t_sel;

    typedef struct packed {
        logic [30:0] res_e;
        logic [30:0] res_d;
        logic [30:0] res_c;
        logic [29:0] res_b;
        logic [29:0] res_a;
    } t_req;

    typedef struct packed {
        logic [63:0] value_word;
        logic [1:0]  word_index;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic   valid;
        t_resid a;
        t_resid b;
        t_resid c;
        t_sel   sel;
    } t_mm_req;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ISSUE,
        B_WAIT,
        B_ACC,
        B_OUT
    } t_bstate;

    localparam t_resid MOD [NMOD] = '{
        31'd1073643521, 31'd1073692673, 31'd1073750017, 31'd1073815553, 31'd1073872897
    };

    localparam t_resid INV [NMOD] = '{
        31'd0, 31'd357919402, 31'd589973977, 31'd197295683, 31'd1004546623
    };

    // barrett factors, floor(2^62 / m)
    localparam logic [32:0] MU [NMOD] = '{
        33'((64'd1 << 62) / 64'd1073643521),
        33'((64'd1 << 62) / 64'd1073692673),
        33'((64'd1 << 62) / 64'd1073750017),
        33'((64'd1 << 62) / 64'd1073815553),
        33'((64'd1 << 62) / 64'd1073872897)
    };

    localparam logic [1:0] LAST_WORD = 2'd2;

endpackage

/* rtl/core/crt_garner_five_moduli_top.sv */
// when the back end is idle, a request goes through the queue, the modular passes and
// the limb accumulator, then comes out as three words on consecutive cycles
// the back end takes one request at a time; its rate is set by the ten dependent passes
// through the four-stage modular multiplier and by the limb accumulator
// a two-entry queue takes requests while the back end works; busy when it is full
// synchronous active-low reset clears the queue and the sequencer; the receiver cannot stall
module crt_garner_five_moduli_top
    import crtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_req q_in;
    t_req q_head;

    crtg_front u_front (
        .i_start (start),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_req   (q_in)
    );

    crtg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    crtg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_strobe  (o_strobe),
        .o_rsp     (o_rsp)
    );

endmodule

/* rtl/core/crtg_front.sv */
module crtg_front
    import crtg_pkg::*;
(
    input  logic i_start,
    input  t_req i_req,
    input  logic i_full,
    output logic o_busy,
    output logic o_push,
    output t_req o_req
);

    logic [30:0] ra;
    logic [30:0] rb;

    // fold residues at or above the modulus
    always_comb begin
        ra = 31'(i_req.res_a);
        rb = 31'(i_req.res_b);
        o_req.res_a = (ra >= MOD[0]) ? 30'(ra - MOD[0]) : i_req.res_a;
        o_req.res_b = (rb >= MOD[1]) ? 30'(rb - MOD[1]) : i_req.res_b;
        o_req.res_c = (i_req.res_c >= MOD[2]) ? (i_req.res_c - MOD[2]) : i_req.res_c;
        o_req.res_d = (i_req.res_d >= MOD[3]) ? (i_req.res_d - MOD[3]) : i_req.res_d;
        o_req.res_e = (i_req.res_e >= MOD[4]) ? (i_req.res_e - MOD[4]) : i_req.res_e;
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

endmodule

/* rtl/core/crtg_queue.sv */
module crtg_queue
    import crtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_req o_head
);

    t_req       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_ent[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/core/crtg_mulmod.sv */
module crtg_mulmod
    import crtg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output logic    o_valid,
    output t_resid  o_res
);

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_v4;
    t_sel        r_s1;
    t_sel        r_s2;
    t_sel        r_s3;
    logic [61:0] r_x1;
    logic [61:0] r_x2;
    logic [32:0] r_q2;
    logic [33:0] r_r3;
    t_resid      r_out;

    logic [64:0] p2;
    logic [63:0] p3;
    logic [33:0] m4;
    logic [33:0] c1;
    logic [33:0] c2;
    logic [33:0] c3;

    always_comb begin
        p2 = 65'(r_x1[61:30]) * 65'(MU[r_s1]);
        p3 = 64'(r_q2) * 64'(MOD[r_s2]);
        m4 = 34'(MOD[r_s3]);
        c1 = (r_r3 >= m4) ? (r_r3 - m4) : r_r3;
        c2 = (c1 >= m4) ? (c1 - m4) : c1;
        c3 = (c2 >= m4) ? (c2 - m4) : c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1  <= 62'(i_req.a) * 62'(i_req.b) + 62'(i_req.c);
        r_s1  <= i_req.sel;
        r_q2  <= p2[64:32];
        r_x2  <= r_x1;
        r_s2  <= r_s1;
        r_r3  <= r_x2[33:0] - p3[33:0];
        r_s3  <= r_s2;
        r_out <= c3[30:0];
    end

    assign o_valid = r_v4;
    assign o_res   = r_out;

endmodule

/* rtl/core/crtg_back.sv */
module crtg_back
    import crtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_req i_q_head,
    output logic o_pop,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_bstate      r_state;
    t_bstate      n_state;
    t_resid       r_res [NMOD];
    t_resid       r_dig [NMOD];
    t_resid       r_t;
    t_resid       n_t;
    t_sel         r_k;
    t_sel         n_k;
    t_sel         r_j;
    t_sel         n_j;
    logic [159:0] r_acc;
    logic [159:0] n_acc;
    logic [31:0]  r_carry;
    logic [31:0]  n_carry;
    logic [2:0]   r_limb;
    logic [2:0]   n_limb;
    logic [1:0]   r_w;
    logic [1:0]   n_w;
    logic         r_strobe;
    t_rsp         r_rsp;
    t_rsp         n_rsp;

    t_mm_req      mm_req;
    logic         mm_valid;
    t_resid       mm_res;
    t_sel         dig_addr;
    t_resid       dig_rd;
    logic [31:0]  diff_w;
    t_resid       diff;
    logic [63:0]  cur;
    logic         load;
    logic         dig_we;

    crtg_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_valid (mm_valid),
        .o_res   (mm_res)
    );

    always_comb begin
        dig_addr = (r_state == B_ACC) ? (r_k - 3'd1) : (r_j - 3'd1);
        dig_rd   = (dig_addr < 3'(NMOD)) ? r_dig[dig_addr] : '0;
        diff_w   = 32'(r_res[r_k]) + 32'(MOD[r_k]) - 32'(r_t);
        diff     = (diff_w >= 32'(MOD[r_k])) ? 31'(diff_w - 32'(MOD[r_k])) : 31'(diff_w);
        cur      = 64'(r_acc[31:0]) * 64'(MOD[r_k]) + 64'(r_carry);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = B_ISSUE;
                end
            end
            B_ISSUE: begin
                n_state = B_WAIT;
            end
            B_WAIT: begin
                if (mm_valid) begin
                    if (r_j == 3'd0 && r_k == 3'd4) begin
                        n_state = B_ACC;
                    end else begin
                        n_state = B_ISSUE;
                    end
                end
            end
            B_ACC: begin
                if (r_limb == 3'd4 && r_k == 3'd0) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (r_w == LAST_WORD) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_t      = r_t;
        n_k      = r_k;
        n_j      = r_j;
        n_acc    = r_acc;
        n_carry  = r_carry;
        n_limb   = r_limb;
        n_w      = r_w;
        n_rsp    = r_rsp;
        load     = 1'b0;
        dig_we   = 1'b0;
        o_pop    = 1'b0;
        mm_req   = '0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    load  = 1'b1;
                    n_t   = 31'(i_q_head.res_a);
                    n_k   = 3'd1;
                    n_j   = 3'd0;
                end
            end
            B_ISSUE: begin
                mm_req.valid = 1'b1;
                mm_req.sel   = r_k;
                if (r_j != 3'd0) begin
                    // horner step of the partial value
                    mm_req.a = r_t;
                    mm_req.b = MOD[r_j - 3'd1];
                    mm_req.c = dig_rd;
                end else begin
                    mm_req.a = diff;
                    mm_req.b = INV[r_k];
                    mm_req.c = '0;
                end
            end
            B_WAIT: begin
                if (mm_valid) begin
                    if (r_j != 3'd0) begin
                        n_t = mm_res;
                        n_j = r_j - 3'd1;
                    end else begin
                        dig_we = 1'b1;
                        if (r_k == 3'd4) begin
                            n_acc   = 160'(mm_res);
                            n_k     = 3'd3;
                            n_limb  = 3'd0;
                            n_carry = 32'(r_dig[3]);
                        end else begin
                            n_t = mm_res;
                            n_j = r_k;
                            n_k = r_k + 3'd1;
                        end
                    end
                end
            end
            B_ACC: begin
                n_acc   = {cur[31:0], r_acc[159:32]};
                n_carry = cur[63:32];
                if (r_limb == 3'd4) begin
                    n_limb = 3'd0;
                    if (r_k == 3'd0) begin
                        n_w = 2'd0;
                    end else begin
                        n_k     = r_k - 3'd1;
                        n_carry = 32'(dig_rd);
                    end
                end else begin
                    n_limb = r_limb + 3'd1;
                end
            end
            B_OUT: begin
                case (r_w)
                    2'd0:    n_rsp.value_word = r_acc[63:0];
                    2'd1:    n_rsp.value_word = r_acc[127:64];
                    default: n_rsp.value_word = 64'(r_acc[159:128]);
                endcase
                n_rsp.word_index = r_w;
                n_rsp.last       = (r_w == LAST_WORD);
                n_w              = r_w + 2'd1;
            end
            default: begin
                n_t = r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == B_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_k     <= n_k;
        r_j     <= n_j;
        r_acc   <= n_acc;
        r_carry <= n_carry;
        r_limb  <= n_limb;
        r_w     <= n_w;
        r_rsp   <= n_rsp;
        if (load) begin
            r_res[0] <= 31'(i_q_head.res_a);
            r_res[1] <= 31'(i_q_head.res_b);
            r_res[2] <= i_q_head.res_c;
            r_res[3] <= i_q_head.res_d;
            r_res[4] <= i_q_head.res_e;
            r_dig[0] <= 31'(i_q_head.res_a);
        end
        if (dig_we) begin
            r_dig[r_k] <= mm_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import crtg_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    int n_errors = 0;
    int n_mismatch = 0;
    int cycle_count = 0;
    int idle_pct = 0;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] MODS [5] = '{64'd1073643521, 64'd1073692673,
        64'd1073750017, 64'd1073815553, 64'd1073872897};
    localparam logic [63:0] INVS [5] = '{64'd0, 64'd357919402, 64'd589973977,
        64'd197295683, 64'd1004546623};

    class crt_scoreboard;
        t_rsp word_q[$];

        function void note_request(t_req r);
            logic [63:0] res [5];
            logic [63:0] dig [5];
            logic [63:0] t;
            logic [63:0] diff;
            logic [191:0] v;
            t_rsp w;
            res[0] = 64'(r.res_a);
            res[1] = 64'(r.res_b);
            res[2] = 64'(r.res_c);
            res[3] = 64'(r.res_d);
            res[4] = 64'(r.res_e);
            for (int k = 0; k < 5; k++) begin
                if (res[k] >= MODS[k]) res[k] = res[k] - MODS[k];
            end
            dig[0] = res[0];
            for (int k = 1; k < 5; k++) begin
                t = dig[k-1] % MODS[k];
                for (int j = k - 2; j >= 0; j--)
                    t = ((t * (MODS[j] % MODS[k])) % MODS[k] + dig[j]) % MODS[k];
                diff = (res[k] + MODS[k] - t) % MODS[k];
                dig[k] = (diff * INVS[k]) % MODS[k];
            end
            v = 192'(dig[4]);
            for (int k = 3; k >= 0; k--)
                v = v * 192'(MODS[k]) + 192'(dig[k]);
            for (int k = 0; k < 3; k++) begin
                w.value_word = v[64*k +: 64];
                w.word_index = 2'(k);
                w.last = (k == 2);
                word_q.push_back(w);
            end
        endfunction

        function void check_word(t_rsp got);
            t_rsp exp;
            if (word_q.size() == 0) begin
                n_errors++;
                if (n_mismatch++ < 10) $display("unexpected word %h", got);
                return;
            end
            exp = word_q.pop_front();
            if (got.value_word !== exp.value_word || got.word_index !== exp.word_index
                    || got.last !== exp.last) begin
                n_errors++;
                if (n_mismatch++ < 10)
                    $display("mismatch exp %h/%0d/%0d got %h/%0d/%0d",
                        exp.value_word, exp.word_index, exp.last,
                        got.value_word, got.word_index, got.last);
            end
        endfunction
    endclass

    crt_scoreboard sb = new();

    crt_garner_five_moduli_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_strobe(o_strobe), .o_rsp(o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) sb.check_word(o_rsp);
        if (i_rst_n && start && !busy) sb.note_request(i_req);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_resid(int k, int mode);
        logic [63:0] top;
        top = (k < 2) ? 64'h3FFF_FFFF : 64'h7FFF_FFFF;
        if (2 * MODS[k] - 1 < top) top = 2 * MODS[k] - 1;
        case (mode)
            0: return 64'd0;
            1: return MODS[k] - 1;
            2: return MODS[k];
            3: return top;
            4: return 64'($urandom_range(0, 3));
            default: return (64'($urandom) % (top + 1));
        endcase
    endfunction

    task automatic send_req(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_mixed(int mode);
        t_req r;
        r.res_a = 30'(rand_resid(0, mode < 0 ? $urandom_range(0, 7) : mode));
        r.res_b = 30'(rand_resid(1, mode < 0 ? $urandom_range(0, 7) : mode));
        r.res_c = 31'(rand_resid(2, mode < 0 ? $urandom_range(0, 7) : mode));
        r.res_d = 31'(rand_resid(3, mode < 0 ? $urandom_range(0, 7) : mode));
        r.res_e = 31'(rand_resid(4, mode < 0 ? $urandom_range(0, 7) : mode));
        send_req(r);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.word_q.size() != 0) @(negedge i_clk);
        while (guard < 100) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    initial begin
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, reduction and top word
        for (int m = 0; m < 6; m++) send_mixed(m);
        for (int i = 0; i < 14; i++) send_mixed(-1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 56 : (ph == 3 ? 19 : 0);
            for (int i = 0; i < 33; i++) send_mixed($urandom_range(0, 9) < 7 ? 9 : -1);
            drain();
        end

        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
